[hw/rtl/tbim_pkg.sv]
package tbim_pkg;

   localparam int MASS_BITS = 17;
   localparam int INV_MASS_BITS = 23;
   localparam logic [INV_MASS_BITS-1:0] INV_MASS_MAX = '1;

   typedef struct packed {
      logic [INV_MASS_BITS-1:0] inv_mass;
      logic                     radicand_negative;
   } rsp_payload_type;

endpackage

[hw/rtl/tbim_if.sv]
interface tbim_if #(parameter int WIDTH = 8);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/tbim_sqrt_stage.sv]
// One step of a restoring integer square root: two radicand bits enter per step.
module tbim_sqrt_stage #(
   parameter int RAD_BITS  = 16,
   parameter int ROOT_BITS = 8,
   parameter int STEP      = 0
) (
   input  logic [RAD_BITS-1:0]  rad_in,
   input  logic [ROOT_BITS+1:0] rem_in,
   input  logic [ROOT_BITS-1:0] root_in,
   output logic [ROOT_BITS+1:0] rem_out,
   output logic [ROOT_BITS-1:0] root_out
);
   logic [ROOT_BITS+3:0] trial;
   logic [ROOT_BITS+3:0] shifted;
   logic [1:0]           pair;

   always_comb begin
      pair     = rad_in[RAD_BITS-1-2*STEP -: 2];
      shifted  = {rem_in, pair};
      trial    = {2'b00, root_in, 2'b01};
      if (shifted >= trial) begin
         rem_out  = (ROOT_BITS+2)'(shifted - trial);
         root_out = {root_in[ROOT_BITS-2:0], 1'b1};
      end else begin
         rem_out  = (ROOT_BITS+2)'(shifted);
         root_out = {root_in[ROOT_BITS-2:0], 1'b0};
      end
   end
endmodule

[hw/rtl/tbim_sqrt_pipe.sv]
// Pipelined integer square root rounded down, STEPS_PER_STAGE bits of root per register stage.
// Carries a side word and valid alongside; stalls with the enable.
module tbim_sqrt_pipe #(
   parameter int RAD_BITS        = 16,
   parameter int SIDE_BITS       = 1,
   parameter int STEPS_PER_STAGE = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       enable,
   input  logic                       in_valid,
   input  logic [RAD_BITS-1:0]        in_rad,
   input  logic [SIDE_BITS-1:0]       in_side,
   output logic                       out_valid,
   output logic [(RAD_BITS+1)/2-1:0]  out_root,
   output logic [SIDE_BITS-1:0]       out_side
);
   localparam int ROOT_BITS = (RAD_BITS + 1) / 2;
   localparam int PAD_BITS  = 2 * ROOT_BITS;
   localparam int STAGES    = (ROOT_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

   logic [PAD_BITS-1:0]  rad_ff  [STAGES];
   logic [ROOT_BITS+1:0] rem_ff  [STAGES];
   logic [ROOT_BITS-1:0] root_ff [STAGES];
   logic [SIDE_BITS-1:0] side_ff [STAGES];
   logic [STAGES-1:0]    valid_ff;

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic [PAD_BITS-1:0]  rad_w;
      logic [SIDE_BITS-1:0] side_w;
      logic                 valid_w;
      logic [ROOT_BITS+1:0] rem_w  [STEPS_PER_STAGE+1];
      logic [ROOT_BITS-1:0] root_w [STEPS_PER_STAGE+1];
      if (s == 0) begin : g_first
         assign rad_w     = PAD_BITS'(in_rad);
         assign side_w    = in_side;
         assign valid_w   = in_valid;
         assign rem_w[0]  = '0;
         assign root_w[0] = '0;
      end else begin : g_next
         assign rad_w     = rad_ff[s-1];
         assign side_w    = side_ff[s-1];
         assign valid_w   = valid_ff[s-1];
         assign rem_w[0]  = rem_ff[s-1];
         assign root_w[0] = root_ff[s-1];
      end
      for (genvar k = 0; k < STEPS_PER_STAGE; k++) begin : g_step
         if (s * STEPS_PER_STAGE + k < ROOT_BITS) begin : g_on
            tbim_sqrt_stage #(
               .RAD_BITS (PAD_BITS),
               .ROOT_BITS(ROOT_BITS),
               .STEP     (s * STEPS_PER_STAGE + k)
            ) u_step (
               .rad_in  (rad_w),
               .rem_in  (rem_w[k]),
               .root_in (root_w[k]),
               .rem_out (rem_w[k+1]),
               .root_out(root_w[k+1])
            );
         end else begin : g_off
            assign rem_w[k+1]  = rem_w[k];
            assign root_w[k+1] = root_w[k];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (enable) begin
            valid_ff[s] <= valid_w;
         end
         if (enable) begin
            rad_ff[s]  <= rad_w;
            rem_ff[s]  <= rem_w[STEPS_PER_STAGE];
            root_ff[s] <= root_w[STEPS_PER_STAGE];
            side_ff[s] <= side_w;
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_root  = root_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];
endmodule

[hw/rtl/tbim_square_sum.sv]
// Registered sum of squares: squares in one stage, adder tree in the next.
module tbim_square_sum #(
   parameter int IN_BITS = 18,
   parameter int TERMS   = 4
) (
   input  logic                        clock,
   input  logic                        enable,
   input  logic signed [IN_BITS-1:0]   terms [TERMS],
   output logic [2*IN_BITS+1:0]        sum
);
   localparam int SQ_BITS = 2 * IN_BITS;
   logic [SQ_BITS-1:0]   sq_ff [TERMS];
   logic [SQ_BITS+1:0]   sum_ff;
   logic [SQ_BITS+1:0]   sum_in;

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < TERMS; i++) begin
            sq_ff[i] <= SQ_BITS'($signed(terms[i]) * $signed(terms[i]));
         end
         sum_ff <= sum_in;
      end
   end

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < TERMS; i++) begin
         sum_in = sum_in + (SQ_BITS+2)'(sq_ff[i]);
      end
   end

   assign sum = sum_ff;
endmodule

[hw/rtl/two_body_invariant_mass.sv]
// Pipeline order: the squares and their sum, the energy root pipelines, the energy
// sum, its square and the squared mass, then the mass root pipeline and the output
// register; 4 root bits per stage. Throughput: one item per cycle; the whole pipe
// advances whenever the output register is empty or being taken. Reset clears the
// valid bits only; no other state.
module two_body_invariant_mass #(
   parameter int MOMENTUM_BITS = 18,
   parameter int FRACTION_BITS = 4
) (
   input  logic clock,
   input  logic reset,
   tbim_if.sink   req,
   tbim_if.source rsp
);
   import tbim_pkg::*;

   localparam int MB    = MOMENTUM_BITS;
   localparam int TB    = (MB > MASS_BITS ? MB : MASS_BITS) + 1;  // energy term width
   localparam int EBITS = 2 * TB;                 // |p|^2 + m^2 magnitude bits
   localparam int ERAD  = EBITS + 2 * FRACTION_BITS;
   localparam int EROOT = (ERAD + 1) / 2;
   localparam int SBITS = EROOT + 1;              // energy sum
   localparam int E2B   = 2 * SBITS;
   localparam int PB    = MB + 1;                 // summed momentum component
   localparam int P2B   = 2 * PB + 2;
   localparam int P2H   = P2B / 2;
   localparam int MROOT = (E2B + 1) / 2;

   logic advance;
   logic [MB-1:0] pxa, pya, pza, pxb, pyb, pzb;
   logic [MASS_BITS-1:0] ma, mb;

   assign {pxa, pya, pza, ma, pxb, pyb, pzb, mb} = req.data;
   assign req.ready = advance;

   logic signed [TB-1:0] terms_a [4];
   logic signed [TB-1:0] terms_b [4];
   logic signed [PB:0] terms_p [3];
   logic [2*TB+1:0] e2a, e2b;
   logic [2*PB+3:0] p2_sum;

   always_comb begin
      terms_a[0] = TB'($signed(pxa));
      terms_a[1] = TB'($signed(pya));
      terms_a[2] = TB'($signed(pza));
      terms_a[3] = $signed(TB'(ma));
      terms_b[0] = TB'($signed(pxb));
      terms_b[1] = TB'($signed(pyb));
      terms_b[2] = TB'($signed(pzb));
      terms_b[3] = $signed(TB'(mb));
      terms_p[0] = (PB+1)'($signed(pxa)) + (PB+1)'($signed(pxb));
      terms_p[1] = (PB+1)'($signed(pya)) + (PB+1)'($signed(pyb));
      terms_p[2] = (PB+1)'($signed(pza)) + (PB+1)'($signed(pzb));
   end

   tbim_square_sum #(.IN_BITS(TB), .TERMS(4)) u_sq_a (
      .clock(clock), .enable(advance), .terms(terms_a), .sum(e2a));
   tbim_square_sum #(.IN_BITS(TB), .TERMS(4)) u_sq_b (
      .clock(clock), .enable(advance), .terms(terms_b), .sum(e2b));
   tbim_square_sum #(.IN_BITS(PB+1), .TERMS(3)) u_sq_p (
      .clock(clock), .enable(advance), .terms(terms_p), .sum(p2_sum));

   logic [1:0] v_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= {v_ff[0], req.valid};
      end
   end

   // Each energy has its own root pipeline; the squared momentum sum rides
   // along, its low half beside one energy and its high half beside the other.
   logic           ea_valid;
   logic [EROOT-1:0] ea, eb;
   logic [P2H-1:0] p2_lo, p2_hi;
   logic           eb_valid;

   tbim_sqrt_pipe #(.RAD_BITS(ERAD), .SIDE_BITS(P2H)) u_root_a (
      .clock(clock), .reset(reset), .enable(advance), .in_valid(v_ff[1]),
      .in_rad({e2a[EBITS-1:0], {(2*FRACTION_BITS){1'b0}}}),
      .in_side(p2_sum[P2H-1:0]),
      .out_valid(ea_valid), .out_root(ea), .out_side(p2_lo));
   tbim_sqrt_pipe #(.RAD_BITS(ERAD), .SIDE_BITS(P2H)) u_root_b (
      .clock(clock), .reset(reset), .enable(advance), .in_valid(v_ff[1]),
      .in_rad({e2b[EBITS-1:0], {(2*FRACTION_BITS){1'b0}}}),
      .in_side(p2_sum[P2B-1:P2H]),
      .out_valid(eb_valid), .out_root(eb), .out_side(p2_hi));

   // Energy sum, then squared sum, then difference.
   logic [SBITS-1:0] es_ff;
   logic [P2B-1:0]   p2_ff, p2b_ff;
   logic [E2B-1:0]   e2_ff;
   logic [E2B-1:0]   rad_ff;
   logic             neg_ff;
   logic [2:0]       d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff <= '0;
      end else if (advance) begin
         d_ff <= {d_ff[1:0], ea_valid & eb_valid};
      end
      if (advance) begin
         es_ff  <= SBITS'(ea) + SBITS'(eb);
         p2_ff  <= {p2_hi, p2_lo};
         e2_ff  <= E2B'(es_ff) * E2B'(es_ff);
         p2b_ff <= p2_ff;
         if (e2_ff < (E2B'(p2b_ff) << (2 * FRACTION_BITS))) begin
            rad_ff <= '0;
            neg_ff <= 1'b1;
         end else begin
            rad_ff <= e2_ff - (E2B'(p2b_ff) << (2 * FRACTION_BITS));
            neg_ff <= 1'b0;
         end
      end
   end

   logic           m_valid;
   logic [MROOT-1:0] m_root;
   logic           m_neg;

   tbim_sqrt_pipe #(.RAD_BITS(E2B), .SIDE_BITS(1)) u_root_m (
      .clock(clock), .reset(reset), .enable(advance), .in_valid(d_ff[2]),
      .in_rad(rad_ff), .in_side(neg_ff),
      .out_valid(m_valid), .out_root(m_root), .out_side(m_neg));

   // Output register.
   logic            out_valid_ff;
   rsp_payload_type out_ff;
   logic [INV_MASS_BITS-1:0] sat;

   always_comb begin
      if (MROOT > INV_MASS_BITS && (m_root >> INV_MASS_BITS) != '0) begin
         sat = INV_MASS_MAX;
      end else begin
         sat = INV_MASS_BITS'(m_root);
      end
   end

   assign advance = !out_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= m_valid;
      end
      if (advance) begin
         out_ff.inv_mass          <= sat;
         out_ff.radicand_negative <= m_neg;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.data  = out_ff;
endmodule
